// ===== sv/rsi_threshold_trader_defines.svh =====
// ----------------------------------------------------------------------------
// rsi_threshold_trader_defines.svh
// Assertion macros shared by the RSI trader checker.
// ----------------------------------------------------------------------------
`ifndef RSI_THRESHOLD_TRADER_DEFINES_SVH
`define RSI_THRESHOLD_TRADER_DEFINES_SVH

// Property checked every clock, masked while reset is high
`define RTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked every clock, reset included
`define RTT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/rtt_pkg.sv =====
// ----------------------------------------------------------------------------
// rtt_pkg
// Types and constants of the RSI threshold trader.
// ----------------------------------------------------------------------------
package rtt_pkg;

  // Parameter defaults
  localparam int MAX_WINDOW_DEF = 64;
  localparam int PRICE_BITS_DEF = 32;
  localparam int OUT_DEPTH      = 8;

  // Fixed field widths
  localparam int WL_W   = 7;
  localparam int LIM_W  = 8;
  localparam int BND_W  = 14;
  localparam int CFG_W  = 14;
  localparam int POS_W  = 9;
  localparam int CASH_W = 48;

  // Register reset values
  localparam logic [WL_W-1:0]  WIN_RESET    = 7'd14;
  localparam logic [LIM_W-1:0] MAXPOS_RESET = 8'd5;
  localparam logic [BND_W-1:0] UPPER_RESET  = 14'd7000;
  localparam logic [BND_W-1:0] LOWER_RESET  = 14'd3000;

  // 100 percent in hundredths of a percent
  localparam logic [BND_W-1:0] RSI_FULL = 14'd10000;

  // Saturation limits of cash and value
  localparam logic signed [CASH_W-1:0] CASH_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [CASH_W-1:0] CASH_MIN = 48'sh8000_0000_0000;

  typedef enum logic [1:0] {
    CFG_WINDOW_LENGTH = 2'd0,
    CFG_MAX_POSITION  = 2'd1,
    CFG_UPPER_BOUND   = 2'd2,
    CFG_LOWER_BOUND   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_BUY  = 2'd1,
    ACT_SELL = 2'd2
  } action_t;

  typedef struct packed {
    logic                     warming;
    action_t                  action;
    logic signed [POS_W-1:0]  position;
    logic signed [CASH_W-1:0] cash_net;
    logic signed [CASH_W-1:0] marked_value;
  } result_t;

endpackage

// ===== sv/rsi_threshold_trader.sv =====
// ----------------------------------------------------------------------------
// rsi_threshold_trader
// Simple-window RSI with threshold buy/sell and running cash and value.
// ----------------------------------------------------------------------------
// The block takes one closing price per clock, back to back, while in_stall is
// low, and returns one result beat per price through the stage registers and
// the result queue. The rate is set by the change ring: one write of the
// newest change and one read of the change leaving the window per item, both
// on the accept edge, and the gain and loss sums are updated once per item in
// the stage after. Results wait in an eight-deep queue; in_stall rises only
// while eight accepted items are not yet delivered. The ring needs no clearing
// pass after reset, as a window restart re-fills it before an entry is read.
module rsi_threshold_trader #(
  parameter int MAX_WINDOW = rtt_pkg::MAX_WINDOW_DEF,
  parameter int PRICE_BITS = rtt_pkg::PRICE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // price channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [PRICE_BITS-1:0]              close_price,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               warming,
  output logic [1:0]                         action,
  output logic signed [rtt_pkg::POS_W-1:0]   position,
  output logic signed [rtt_pkg::CASH_W-1:0]  cash_net,
  output logic signed [rtt_pkg::CASH_W-1:0]  marked_value,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [rtt_pkg::CFG_W-1:0]          cfg_data
);
  import rtt_pkg::*;

  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 2);
  localparam int EXT_W  = (CNT_W > WL_W) ? CNT_W : WL_W;
  localparam int CHG_W  = PRICE_BITS + 1;
  localparam int SUM_W  = PRICE_BITS + $clog2(MAX_WINDOW + 1);
  localparam int PRD_W  = SUM_W + BND_W;
  localparam int MUL_W  = PRICE_BITS + POS_W + 1;
  localparam int CADD_W = ((CHG_W > CASH_W) ? CHG_W : CASH_W) + 1;
  localparam int MADD_W = ((MUL_W > CASH_W) ? MUL_W : CASH_W) + 1;
  localparam int OCC_W  = $clog2(OUT_DEPTH + 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [WL_W-1:0]  window_length;
  logic [LIM_W-1:0] pos_limit;
  logic [BND_W-1:0] upper_bound;
  logic [BND_W-1:0] buy_bound;
  logic             cfg_we;
  logic             wl_write;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign wl_write  = cfg_we && (cfg_reg_t'(cfg_index) == CFG_WINDOW_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WIN_RESET;
      pos_limit     <= MAXPOS_RESET;
      upper_bound   <= UPPER_RESET;
      buy_bound     <= LOWER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_WINDOW_LENGTH: window_length <= cfg_data[WL_W-1:0];
        CFG_MAX_POSITION:  pos_limit     <= cfg_data[LIM_W-1:0];
        CFG_UPPER_BOUND:   upper_bound   <= cfg_data[BND_W-1:0];
        CFG_LOWER_BOUND:   buy_bound     <= cfg_data[BND_W-1:0];
      endcase
    end
  end

  // effective window: zero acts as one, clipped to the ring depth
  logic [EXT_W-1:0] wl_ext;
  logic [CNT_W-1:0] win_n;

  assign wl_ext = EXT_W'(window_length);

  always_comb begin
    if (window_length == '0) begin
      win_n = CNT_W'(1);
    end else if (wl_ext > EXT_W'(MAX_WINDOW)) begin
      win_n = CNT_W'(MAX_WINDOW);
    end else begin
      win_n = CNT_W'(wl_ext);
    end
  end

  // --------------------------------------------------------------------------
  // Handshakes and credit count
  // --------------------------------------------------------------------------
  logic             in_acc;
  logic             out_hs;
  logic [OCC_W-1:0] occ;

  // stage valid flags
  logic v1, v2, v3, v4, v5;

  assign in_stall = (occ == OCC_W'(OUT_DEPTH));
  assign in_acc   = in_valid && !in_stall;
  assign out_hs   = out_valid && !out_stall;

  // items accepted and not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      unique case ({in_acc, out_hs})
        2'b10:   occ <= occ + 1'b1;
        2'b01:   occ <= occ - 1'b1;
        default: occ <= occ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Accept stage: change, ring write, read of the leaving change
  // --------------------------------------------------------------------------
  logic [PTR_W-1:0]        ring_ptr;
  logic [PRICE_BITS-1:0]   prev_close;
  logic [CNT_W-1:0]        items_seen;
  logic                    has_prev;
  logic                    full;
  logic signed [CHG_W-1:0] chg0;
  logic [CNT_W:0]          old_diff;
  logic [CNT_W:0]          old_wrap;
  logic [PTR_W-1:0]        rd_addr;

  assign has_prev = (items_seen != '0);
  assign full     = (items_seen > win_n);
  assign chg0     = $signed({1'b0, close_price}) - $signed({1'b0, prev_close});

  // oldest entry sits win_n places behind the write pointer
  assign old_diff = (CNT_W + 1)'(ring_ptr) - (CNT_W + 1)'(win_n);
  assign old_wrap = old_diff[CNT_W] ? old_diff + (CNT_W + 1)'(MAX_WINDOW) : old_diff;
  assign rd_addr  = old_wrap[PTR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_ptr   <= '0;
      prev_close <= '0;
      items_seen <= '0;
    end else begin
      if (in_acc) begin
        prev_close <= close_price;
        if (has_prev) begin
          ring_ptr <= (ring_ptr == PTR_W'(MAX_WINDOW - 1)) ? '0 : ring_ptr + 1'b1;
        end
        if (!full) begin
          items_seen <= items_seen + 1'b1;
        end
      end
      if (wl_write) begin
        items_seen <= '0;
      end
    end
  end

  // change ring, read-first on a shared address
  logic signed [CHG_W-1:0] ring_mem [MAX_WINDOW];
  logic signed [CHG_W-1:0] ring_rd;

  always_ff @(posedge clk) begin
    if (in_acc && has_prev) begin
      ring_mem[ring_ptr] <= chg0;
    end
    if (in_acc) begin
      ring_rd <= ring_mem[rd_addr];
    end
  end

  // stage 1 registers
  logic [PRICE_BITS-1:0]   p1_close;
  logic signed [CHG_W-1:0] p1_chg;
  logic                    p1_has_prev;
  logic                    p1_full;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p1_close    <= close_price;
      p1_chg      <= chg0;
      p1_has_prev <= has_prev;
      p1_full     <= full;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: running gain and loss sums
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0]      gain_sum;
  logic [SUM_W-1:0]      loss_sum;
  logic [CHG_W-1:0]      chg_neg;
  logic [CHG_W-1:0]      gone_neg;
  logic [PRICE_BITS-1:0] chg_mag;
  logic [PRICE_BITS-1:0] gone_mag;
  logic                  chg_up;
  logic                  gone_up;
  logic [SUM_W-1:0]      gain_add;
  logic [SUM_W-1:0]      loss_add;
  logic [SUM_W-1:0]      gain_sub;
  logic [SUM_W-1:0]      loss_sub;
  logic [SUM_W-1:0]      gain_next;
  logic [SUM_W-1:0]      loss_next;

  assign chg_neg  = -p1_chg;
  assign gone_neg = -ring_rd;
  assign chg_mag  = p1_chg[CHG_W-1] ? chg_neg[PRICE_BITS-1:0] : p1_chg[PRICE_BITS-1:0];
  assign gone_mag = ring_rd[CHG_W-1] ? gone_neg[PRICE_BITS-1:0] : ring_rd[PRICE_BITS-1:0];
  assign chg_up   = !p1_chg[CHG_W-1] && (p1_chg != '0);
  assign gone_up  = !ring_rd[CHG_W-1] && (ring_rd != '0);

  // a zero change counts as a loss of zero
  always_comb begin
    gain_add = '0;
    loss_add = '0;
    gain_sub = '0;
    loss_sub = '0;
    if (p1_has_prev) begin
      if (chg_up) begin
        gain_add = SUM_W'(chg_mag);
      end else begin
        loss_add = SUM_W'(chg_mag);
      end
    end
    if (p1_full) begin
      if (gone_up) begin
        gain_sub = SUM_W'(gone_mag);
      end else begin
        loss_sub = SUM_W'(gone_mag);
      end
    end
  end

  assign gain_next = gain_sum + gain_add - gain_sub;
  assign loss_next = loss_sum + loss_add - loss_sub;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_sum <= '0;
      loss_sum <= '0;
    end else if (wl_write) begin
      gain_sum <= '0;
      loss_sum <= '0;
    end else if (v1) begin
      gain_sum <= gain_next;
      loss_sum <= loss_next;
    end
  end

  // stage 2 registers
  logic                  p2_warm;
  logic [PRICE_BITS-1:0] p2_close;
  logic [SUM_W-1:0]      p2_gain;
  logic [SUM_W-1:0]      p2_total;

  always_ff @(posedge clk) begin
    if (v1) begin
      p2_warm  <= !p1_full;
      p2_close <= p1_close;
      p2_gain  <= gain_next;
      p2_total <= gain_next + loss_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: cross products of RSI against the bounds
  // --------------------------------------------------------------------------
  logic                  p3_warm;
  logic [PRICE_BITS-1:0] p3_close;
  logic                  p3_total_nz;
  logic [PRD_W-1:0]      p3_gain_sc;
  logic [PRD_W-1:0]      p3_lo_sc;
  logic [PRD_W-1:0]      p3_up_sc;

  always_ff @(posedge clk) begin
    if (v2) begin
      p3_warm     <= p2_warm;
      p3_close    <= p2_close;
      p3_total_nz <= (p2_total != '0);
      p3_gain_sc  <= PRD_W'(p2_gain) * PRD_W'(RSI_FULL);
      p3_lo_sc    <= PRD_W'(buy_bound) * PRD_W'(p2_total);
      p3_up_sc    <= PRD_W'(upper_bound) * PRD_W'(p2_total);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: trade decision, position and cash
  // --------------------------------------------------------------------------
  logic signed [POS_W-1:0]  held_units;
  logic signed [CASH_W-1:0] cash_total;
  logic signed [POS_W:0]    held_x;
  logic signed [POS_W:0]    lim;
  logic                     buy;
  logic                     sell;
  logic signed [CADD_W-1:0] cash_ext;
  logic signed [CADD_W-1:0] close_ext;
  logic signed [CADD_W-1:0] cash_sum;
  logic [CADD_W-CASH_W:0]   cash_top;
  logic signed [CASH_W-1:0] cash_sat;
  logic signed [POS_W-1:0]  held_next;
  logic signed [CASH_W-1:0] cash_next;
  action_t                  act_next;

  assign held_x    = {held_units[POS_W-1], held_units};
  assign lim       = $signed({2'b00, pos_limit});
  assign buy       = !p3_warm && p3_total_nz && (p3_gain_sc < p3_lo_sc) && (held_x < lim);
  assign sell      = !p3_warm && p3_total_nz && !buy && (p3_gain_sc > p3_up_sc) &&
                     (held_x > -lim);
  assign cash_ext  = CADD_W'(cash_total);
  assign close_ext = $signed(CADD_W'({1'b0, p3_close}));
  assign cash_sum  = buy ? cash_ext - close_ext : cash_ext + close_ext;
  assign cash_top  = cash_sum[CADD_W-1:CASH_W-1];

  // saturate to the 48-bit signed range
  always_comb begin
    if ((&cash_top) || !(|cash_top)) begin
      cash_sat = cash_sum[CASH_W-1:0];
    end else if (cash_sum[CADD_W-1]) begin
      cash_sat = CASH_MIN;
    end else begin
      cash_sat = CASH_MAX;
    end
  end

  always_comb begin
    held_next = held_units;
    cash_next = cash_total;
    act_next  = ACT_NONE;
    priority if (buy) begin
      held_next = held_units + POS_W'(1);
      cash_next = cash_sat;
      act_next  = ACT_BUY;
    end else if (sell) begin
      held_next = held_units - POS_W'(1);
      cash_next = cash_sat;
      act_next  = ACT_SELL;
    end else begin
      act_next  = ACT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_units <= '0;
      cash_total <= '0;
    end else if (v3) begin
      held_units <= held_next;
      cash_total <= cash_next;
    end
  end

  // stage 4 registers
  logic                     p4_warm;
  logic [PRICE_BITS-1:0]    p4_close;
  action_t                  p4_act;
  logic signed [POS_W-1:0]  p4_held;
  logic signed [CASH_W-1:0] p4_cash;

  always_ff @(posedge clk) begin
    if (v3) begin
      p4_warm  <= p3_warm;
      p4_close <= p3_close;
      p4_act   <= act_next;
      p4_held  <= held_next;
      p4_cash  <= cash_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: position times close
  // --------------------------------------------------------------------------
  logic                     p5_warm;
  action_t                  p5_act;
  logic signed [POS_W-1:0]  p5_held;
  logic signed [CASH_W-1:0] p5_cash;
  logic signed [MUL_W-1:0]  p5_prod;

  always_ff @(posedge clk) begin
    if (v4) begin
      p5_warm <= p4_warm;
      p5_act  <= p4_act;
      p5_held <= p4_held;
      p5_cash <= p4_cash;
      p5_prod <= p4_held * $signed({1'b0, p4_close});
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: marked value and result queue
  // --------------------------------------------------------------------------
  logic signed [MADD_W-1:0] mv_sum;
  logic [MADD_W-CASH_W:0]   mv_top;
  logic signed [CASH_W-1:0] mv_sat;
  result_t                  res_in;
  result_t                  res_out;

  assign mv_sum = MADD_W'(p5_cash) + MADD_W'(p5_prod);
  assign mv_top = mv_sum[MADD_W-1:CASH_W-1];

  always_comb begin
    if ((&mv_top) || !(|mv_top)) begin
      mv_sat = mv_sum[CASH_W-1:0];
    end else if (mv_sum[MADD_W-1]) begin
      mv_sat = CASH_MIN;
    end else begin
      mv_sat = CASH_MAX;
    end
  end

  always_comb begin
    res_in.warming      = p5_warm;
    res_in.action       = p5_act;
    res_in.position     = p5_held;
    res_in.cash_net     = p5_cash;
    res_in.marked_value = mv_sat;
  end

  // stage valid shift
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= in_acc;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  rtt_result_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_result_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (v5),
    .wr_data  (res_in),
    .rd_en    (out_hs),
    .rd_valid (out_valid),
    .rd_data  (res_out)
  );

  assign warming      = res_out.warming;
  assign action       = res_out.action;
  assign position     = res_out.position;
  assign cash_net     = res_out.cash_net;
  assign marked_value = res_out.marked_value;

endmodule

// ===== sv/rtt_result_fifo.sv =====
// ----------------------------------------------------------------------------
// rtt_result_fifo
// Small result queue between the trading pipeline and the output channel.
// ----------------------------------------------------------------------------
module rtt_result_fifo #(
  parameter int DEPTH = rtt_pkg::OUT_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  rtt_pkg::result_t wr_data,
  input  logic             rd_en,
  output logic             rd_valid,
  output rtt_pkg::result_t rd_data
);
  import rtt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t            q_mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_rd;

  assign rd_valid = (count != '0);
  assign rd_data  = q_mem[rd_ptr];
  assign do_rd    = rd_en && rd_valid;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr_en, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/rtt_checker.sv =====
// ----------------------------------------------------------------------------
// rtt_checker
// Port-level checks of the RSI trader result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "rsi_threshold_trader_defines.svh"

module rtt_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              warming,
  input logic [1:0]                        action,
  input logic signed [rtt_pkg::POS_W-1:0]  position,
  input logic signed [rtt_pkg::CASH_W-1:0] cash_net,
  input logic signed [rtt_pkg::CASH_W-1:0] marked_value
);
  import rtt_pkg::*;

  localparam int OUT_W = 1 + 2 + POS_W + 2 * CASH_W;

  logic                     out_hs;
  logic signed [POS_W-1:0]  prev_pos;
  logic signed [CASH_W-1:0] prev_cash;
  logic signed [POS_W-1:0]  pos_up;
  logic signed [POS_W-1:0]  pos_dn;
  logic [OUT_W-1:0]         out_word;
  logic                     pos_ok;
  logic                     cash_ok;

  assign out_hs   = out_valid && !out_stall;
  assign pos_up   = prev_pos + POS_W'(1);
  assign pos_dn   = prev_pos - POS_W'(1);
  assign out_word = {warming, action, position, cash_net, marked_value};
  assign cash_ok  = (action != ACT_NONE) || (cash_net == prev_cash);

  // position must move with the action: up one on a buy, down one on a sell, else unchanged
  always_comb begin
    pos_ok = 1'b0;
    if (action == ACT_NONE) begin
      pos_ok = (position == prev_pos);
    end else if (action == ACT_BUY) begin
      pos_ok = (position == pos_up);
    end else if (action == ACT_SELL) begin
      pos_ok = (position == pos_dn);
    end
  end

  // position and cash of the last delivered beat
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pos  <= '0;
      prev_cash <= '0;
    end else if (out_hs) begin
      prev_pos  <= position;
      prev_cash <= cash_net;
    end
  end

  `RTT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_word), "stalled result beat changed")
  `RTT_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "result beat right after reset")
  `RTT_ASSERT(a_pos_step, out_hs |-> pos_ok, "position step does not match action")
  `RTT_ASSERT(a_cash_hold, out_hs |-> cash_ok, "cash moved without a trade")
  `RTT_ASSERT(a_warm_idle, out_valid && warming |-> action == ACT_NONE, "trade while window warms")

endmodule

bind rsi_threshold_trader rtt_checker u_rtt_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .warming      (warming),
  .action       (action),
  .position     (position),
  .cash_net     (cash_net),
  .marked_value (marked_value)
);

// ===== tb/sv/rtt_trade_checker.sv =====
// ----------------------------------------------------------------------------
// rtt_trade_checker
// Watches the price, result and configuration channels of the RSI trader,
// keeps its own copy of the window, position and cash, and compares every
// result beat field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module rtt_trade_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [rtt_pkg::PRICE_BITS_DEF-1:0] close_price,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic                               warming,
  input  logic [1:0]                         action,
  input  logic signed [rtt_pkg::POS_W-1:0]   position,
  input  logic signed [rtt_pkg::CASH_W-1:0]  cash_net,
  input  logic signed [rtt_pkg::CASH_W-1:0]  marked_value,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [rtt_pkg::CFG_W-1:0]          cfg_data,
  output int                                 fail_count,
  output int                                 results_owed
);
  import rtt_pkg::*;

  localparam int RING_DEPTH = MAX_WINDOW_DEF;
  localparam int RING_W     = $clog2(RING_DEPTH);
  localparam int PX_W       = PRICE_BITS_DEF;
  localparam int SUM_W      = 39;

  // register copies
  logic [WL_W-1:0]  win_len;
  logic [LIM_W-1:0] pos_limit;
  logic [BND_W-1:0] sell_level;
  logic [BND_W-1:0] buy_level;

  // window and trading state
  logic signed [PX_W:0]     changes [RING_DEPTH];
  logic [RING_W-1:0]        ring_wr;
  logic [PX_W-1:0]          last_close;
  logic [SUM_W-1:0]         gains;
  logic [SUM_W-1:0]         losses;
  logic [WL_W-1:0]          warm_count;
  logic signed [POS_W-1:0]  units;
  logic signed [CASH_W-1:0] cash;

  result_t owed_results[$];
  result_t want;
  result_t predicted;
  int      errors;
  int      beat_no;

  function automatic logic signed [CASH_W-1:0] clamp_cash(input logic signed [63:0] v);
    if (v > CASH_MAX) return CASH_MAX;
    if (v < CASH_MIN) return CASH_MIN;
    return v[CASH_W-1:0];
  endfunction

  // one line per mismatch
  task automatic flag_mismatch(input string what);
    errors++;
    $display("MISMATCH at %0t, result beat %0d: %s", $time, beat_no, what);
  endtask

  // advance the window by one close and work out the trade it causes
  task automatic trade_on_close(input logic [PX_W-1:0] px, output result_t res);
    int                 n;
    int                 held;
    int                 lim;
    logic signed [63:0] chg;
    logic signed [63:0] gone;
    logic signed [63:0] px64;
    logic signed [63:0] cash64;
    logic signed [63:0] units64;
    logic [RING_W-1:0]  old_idx;
    logic [63:0]        total;
    logic [63:0]        gain_scaled;
    logic               is_warm;
    action_t            act;

    n = (win_len == 0) ? 1 : ((win_len > RING_DEPTH) ? RING_DEPTH : int'(win_len));
    is_warm = 1'b1;
    act     = ACT_NONE;
    px64    = 64'(px);

    if (warm_count != 0) begin
      chg = px64 - 64'(last_close);
      // zero change goes to the loss side
      if (chg > 0) gains = gains + SUM_W'(chg);
      else losses = losses - SUM_W'(chg);
      if (int'(warm_count) > n) begin
        old_idx = ring_wr - RING_W'(n);
        gone    = changes[old_idx];
        is_warm = 1'b0;
        if (gone > 0) gains = gains - SUM_W'(gone);
        else losses = losses + SUM_W'(gone);
      end
      changes[ring_wr] = chg[PX_W:0];
      ring_wr++;
    end
    if (int'(warm_count) <= n) warm_count++;
    last_close = px;

    cash64 = cash;
    if (!is_warm) begin
      total = 64'(gains) + 64'(losses);
      if (total != 0) begin
        gain_scaled = 64'(gains) * 64'(RSI_FULL);
        held = units;
        lim  = pos_limit;
        // buy is tried first, sell only when buy fails
        if (gain_scaled < 64'(buy_level) * total && held < lim) begin
          units++;
          cash = clamp_cash(cash64 - px64);
          act  = ACT_BUY;
        end else if (gain_scaled > 64'(sell_level) * total && held > -lim) begin
          units--;
          cash = clamp_cash(cash64 + px64);
          act  = ACT_SELL;
        end
      end
    end

    cash64  = cash;
    units64 = units;
    res.warming      = is_warm;
    res.action       = act;
    res.position     = units;
    res.cash_net     = cash;
    res.marked_value = clamp_cash(cash64 + units64 * px64);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      win_len    = WIN_RESET;
      pos_limit  = MAXPOS_RESET;
      sell_level = UPPER_RESET;
      buy_level  = LOWER_RESET;
      for (int i = 0; i < RING_DEPTH; i++) changes[i] = '0;
      ring_wr    = '0;
      last_close = '0;
      gains      = '0;
      losses     = '0;
      warm_count = '0;
      units      = '0;
      cash       = '0;
      owed_results.delete();
      errors  = 0;
      beat_no = 0;
      fail_count   <= 0;
      results_owed <= 0;
    end else begin
      // result beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          flag_mismatch("result beat with no prediction waiting");
        end else begin
          want = owed_results.pop_front();
          if (warming !== want.warming)
            flag_mismatch($sformatf("warming %0d, expected %0d", warming, want.warming));
          if (action !== want.action)
            flag_mismatch($sformatf("action %0d, expected %0d", action, want.action));
          if (position !== want.position)
            flag_mismatch($sformatf("position %0d, expected %0d", position, want.position));
          if (cash_net !== want.cash_net)
            flag_mismatch($sformatf("cash_net %0d, expected %0d",
                                    cash_net, want.cash_net));
          if (marked_value !== want.marked_value)
            flag_mismatch($sformatf("marked_value %0d, expected %0d",
                                    marked_value, want.marked_value));
        end
        beat_no++;
      end

      // register write; a new window length restarts warm-up
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_WINDOW_LENGTH: begin
            win_len    = cfg_data[WL_W-1:0];
            warm_count = '0;
            gains      = '0;
            losses     = '0;
          end
          CFG_MAX_POSITION: pos_limit  = cfg_data[LIM_W-1:0];
          CFG_UPPER_BOUND:  sell_level = cfg_data[BND_W-1:0];
          CFG_LOWER_BOUND:  buy_level  = cfg_data[BND_W-1:0];
          default: ;
        endcase
      end

      // price beat
      if (in_valid && !in_stall) begin
        trade_on_close(close_price, predicted);
        owed_results.insert(owed_results.size(), predicted);
      end

      fail_count   <= errors;
      results_owed <= owed_results.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the RSI threshold trader: a directed price run, then random
// price walks under a series of register settings and flow-control phases.
// ----------------------------------------------------------------------------
module tb;
  import rtt_pkg::*;

  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     in_valid     = 1'b0;
  logic                     in_stall;
  logic [31:0]              close_price  = '0;
  logic                     out_valid;
  logic                     out_stall    = 1'b0;
  logic                     warming;
  logic [1:0]               action;
  logic signed [POS_W-1:0]  position;
  logic signed [CASH_W-1:0] cash_net;
  logic signed [CASH_W-1:0] marked_value;
  logic                     cfg_valid    = 1'b0;
  logic                     cfg_ready;
  logic [1:0]               cfg_index    = '0;
  logic [CFG_W-1:0]         cfg_data     = '0;
  int                       fail_count;
  int                       results_owed;

  // flow-control knobs
  int   src_idle_pct   = 0;
  int   sink_stall_pct = 0;
  logic sink_hold      = 1'b0;
  int   hold_len;

  // price walk
  longint      walk;
  int          trend_left = 0;
  int          trend_dir;
  int unsigned step_max;

  localparam logic [31:0] DIRECTED_PX [24] = '{
    32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0,
    32'd100, 32'd200, 32'd300, 32'd300, 32'd250, 32'd150, 32'd50, 32'd1,
    32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
    32'd1000, 32'd1000, 32'd999, 32'd1001
  };

  rsi_threshold_trader u_dut (.*);
  rtt_trade_checker    u_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side stall
  always @(posedge clk) begin
    out_stall <= sink_hold || ($urandom_range(99) < sink_stall_pct);
  end

  initial begin
    #5_000_000;
    $display("rsi_threshold_trader test failed");
    $finish;
  end

  // one price beat; valid stays up after acceptance until the next call
  task automatic offer_price(input logic [31:0] px);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    close_price <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // raises the write channel and waits for its handshake, leaves valid up
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs(input logic [3:0] mask, input logic [CFG_W-1:0] win,
                              input logic [CFG_W-1:0] lim, input logic [CFG_W-1:0] up,
                              input logic [CFG_W-1:0] lo);
    if (mask[CFG_WINDOW_LENGTH]) write_reg(CFG_WINDOW_LENGTH, win);
    if (mask[CFG_MAX_POSITION])  write_reg(CFG_MAX_POSITION, lim);
    if (mask[CFG_UPPER_BOUND])   write_reg(CFG_UPPER_BOUND, up);
    if (mask[CFG_LOWER_BOUND])   write_reg(CFG_LOWER_BOUND, lo);
    cfg_valid <= 1'b0;
  endtask

  // stop offering and wait for every predicted result to come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // trending random walk with bursts of noise and rail-to-rail jumps
  task automatic next_close(output logic [31:0] px);
    int unsigned roll;
    int unsigned step;
    bit          up;
    if (trend_left == 0) begin
      trend_left = $urandom_range(40, 3);
      trend_dir  = $urandom_range(2);
      case ($urandom_range(4))
        0:       step_max = 0;
        1:       step_max = 50;
        2:       step_max = 5000;
        3:       step_max = 1 << 20;
        default: step_max = 32'h7FFF_FFFF;
      endcase
    end
    trend_left--;
    roll = $urandom_range(99);
    if (roll < 5) begin
      px = $urandom;
    end else if (roll < 8) begin
      px = roll[0] ? 32'hFFFF_FFFF : 32'h0;
    end else begin
      step = $urandom_range(step_max);
      // 2 is a flat market, otherwise 80 percent of steps follow the trend
      if (trend_dir == 2) up = $urandom_range(1);
      else up = ($urandom_range(99) < 80) ^ (trend_dir == 0);
      walk = up ? walk + step : walk - step;
      if (walk < 0) walk = 0;
      if (walk > 64'h0_FFFF_FFFF) walk = 64'h0_FFFF_FFFF;
      px = walk[31:0];
    end
  endtask

  task automatic run_phase(input int items, input int src, input int sink, input int hold,
                           input logic [3:0] mask, input logic [CFG_W-1:0] win,
                           input logic [CFG_W-1:0] lim, input logic [CFG_W-1:0] up,
                           input logic [CFG_W-1:0] lo);
    logic [31:0] px;
    program_regs(mask, win, lim, up, lo);
    src_idle_pct   = src;
    sink_stall_pct <= sink;
    // long receiver hold-off while prices keep coming
    if (hold > 0) begin
      hold_len = hold;
      fork
        begin
          sink_hold <= 1'b1;
          repeat (hold_len) @(posedge clk);
          sink_hold <= 1'b0;
        end
      join_none
    end
    for (int k = 0; k < items; k++) begin
      next_close(px);
      offer_price(px);
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero totals, full-scale gains and losses, position limit of one
    program_regs(4'b1111, 14'd2, 14'd1, 14'd7000, 14'd3000);
    foreach (DIRECTED_PX[i]) offer_price(DIRECTED_PX[i]);
    drain();

    walk = $urandom;
    run_phase(240, 0, 0, 0, 4'b1111, 14'd14, 14'd5, 14'd7000, 14'd3000);
    // thresholds at the rails: no trade possible
    run_phase(120, 82, 0, 0, 4'b1111, 14'd64, 14'd255, 14'd10000, 14'd0);
    // zero window acts as one
    run_phase(220, 0, 82, 0, 4'b1111, 14'd0, 14'd3, 14'd5000, 14'd5000);
    // oversize window acts as the full ring
    run_phase(220, 29, 29, 0, 4'b1111, 14'd127, 14'd1, 14'd6000, 14'd4000);
    // no window restart; zero limit and an upper bound beyond full scale
    run_phase(200, 0, 0, 0, 4'b0110, 14'd0, 14'd0, 14'h3FFF, 14'h3FFF);
    // lower bound above upper: sells once buying hits the limit
    run_phase(220, 82, 0, 0, 4'b1111, 14'd8, 14'd2, 14'd3000, 14'd8000);
    run_phase(220, 0, 82, 0, 4'b1111, 14'($urandom_range(30, 2)),
              14'($urandom_range(20, 1)), 14'($urandom_range(9000, 5000)),
              14'($urandom_range(5000, 1000)));
    run_phase(200, 29, 29, 0, 4'b1101, 14'($urandom_range(10, 1)), 14'd0,
              14'($urandom_range(8000, 5500)), 14'($urandom_range(4500, 2000)));
    // queue fills while the receiver holds off
    run_phase(150, 0, 0, 300, 4'b0000, 14'd0, 14'd0, 14'd0, 14'd0);

    repeat (20) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("rsi_threshold_trader test passed");
    end else begin
      $display("rsi_threshold_trader test failed");
    end
    $finish;
  end

endmodule
